// ===== design/jrt_pkg.sv =====
// ----------------------------------------------------------------------------
// jrt_pkg: shared types and constants for the journal revoke table
// Holds field widths, the operation codes and the compare result record.
// ----------------------------------------------------------------------------
package jrt_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 512;
    localparam int FUNC_W              = 2;
    localparam int BLOCK_W             = 32;
    localparam int SEQ_W               = 32;
    localparam int USED_W              = 10;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR    = 2'd0,
        FUNC_REMEMBER = 2'd1,
        FUNC_QUERY    = 2'd2
    } func_t;

    // Outcome of comparing one stored entry against the request key.
    typedef struct packed {
        logic hit;     // stored block equals the requested block
        logic seq_ge;  // stored sequence >= requested sequence
    } match_t;

endpackage

// ===== design/jrt_store.sv =====
// ----------------------------------------------------------------------------
// jrt_store: entry memory of the revoke table
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module jrt_store #(
    parameter int DEPTH = jrt_pkg::TABLE_DEPTH_DEFAULT,
    parameter int AW    = 9
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [jrt_pkg::BLOCK_W-1:0] wr_block,
    input  logic [jrt_pkg::SEQ_W-1:0]   wr_seq,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [jrt_pkg::BLOCK_W-1:0] rd_block,
    output logic [jrt_pkg::SEQ_W-1:0]   rd_seq
);

    logic [jrt_pkg::BLOCK_W-1:0] block_mem [DEPTH];
    logic [jrt_pkg::SEQ_W-1:0]   seq_mem   [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            block_mem[wr_addr] <= wr_block;
            seq_mem[wr_addr]   <= wr_seq;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_block <= block_mem[rd_addr];
            rd_seq   <= seq_mem[rd_addr];
        end
    end

endmodule

// ===== design/jrt_match.sv =====
// ----------------------------------------------------------------------------
// jrt_match: shared compare unit
// Compares one stored entry with the request's block and sequence.
// ----------------------------------------------------------------------------
module jrt_match (
    input  logic [jrt_pkg::BLOCK_W-1:0] key_block,
    input  logic [jrt_pkg::SEQ_W-1:0]   key_seq,
    input  logic [jrt_pkg::BLOCK_W-1:0] entry_block,
    input  logic [jrt_pkg::SEQ_W-1:0]   entry_seq,
    output jrt_pkg::match_t             result
);

    assign result.hit    = (entry_block == key_block);
    assign result.seq_ge = (entry_seq >= key_seq);

endmodule

// ===== design/journal_revoke_table_core.sv =====
// ----------------------------------------------------------------------------
// journal_revoke_table_core: table of revoked blocks with their sequences
// Clear, remember and query requests; remember and query each make one scan.
// ----------------------------------------------------------------------------
// Flow: clear and the unused code skip the scan; remember and query walk the
//   entries in use until a hit or the end. A new request is accepted only
//   once the last result has moved to the output register; the single memory
//   read port feeding the shared compare unit visits one entry per cycle.
// Reset: aresetn (synchronous, active low) empties the table and idles the
//   sequencer; entry contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module journal_revoke_table_core #(
    parameter int TABLE_DEPTH = jrt_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [jrt_pkg::FUNC_W-1:0]    s_func,
    input  logic [jrt_pkg::BLOCK_W-1:0]   s_block_number,
    input  logic [jrt_pkg::SEQ_W-1:0]     s_sequence_req,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_is_revoked,
    output logic                          m_table_full_error,
    output logic [jrt_pkg::USED_W-1:0]    m_entries_used
);

    // Count must hold TABLE_DEPTH itself; the address only the entry index.
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                      state_reg,      state_next;
    jrt_pkg::func_t              op_reg,         op_next;
    logic [jrt_pkg::BLOCK_W-1:0] blk_reg,        blk_next;
    logic [jrt_pkg::SEQ_W-1:0]   seq_reg,        seq_next;
    logic [CW-1:0]               count_reg,      count_next;
    logic [CW-1:0]               scan_cnt_reg,   scan_cnt_next;
    logic                        rd_pend_reg,    rd_pend_next;
    logic [AW-1:0]               rd_idx_reg,     rd_idx_next;
    logic                        revoked_reg,    revoked_next;
    logic                        full_reg,       full_next;
    logic                        m_valid_reg,    m_valid_next;
    logic                        out_revoked_reg, out_revoked_next;
    logic                        out_full_reg,   out_full_next;
    logic [jrt_pkg::USED_W-1:0]  out_used_reg,   out_used_next;

    logic                        rd_en;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [jrt_pkg::BLOCK_W-1:0] rd_block;
    logic [jrt_pkg::SEQ_W-1:0]   rd_seq;
    jrt_pkg::match_t             match;
    logic                        hit_now;
    logic                        scan_end;

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_is_revoked       = out_revoked_reg;
    assign m_table_full_error = out_full_reg;
    assign m_entries_used     = out_used_reg;

    // Entry memory: the scan reads at scan_cnt, the end of a request writes.
    jrt_store #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_block (blk_reg),
        .wr_seq   (seq_reg),
        .rd_en    (rd_en),
        .rd_addr  (scan_cnt_reg[AW-1:0]),
        .rd_block (rd_block),
        .rd_seq   (rd_seq)
    );

    // Shared compare unit, fed by the registered read data.
    jrt_match u_match (
        .key_block   (blk_reg),
        .key_seq     (seq_reg),
        .entry_block (rd_block),
        .entry_seq   (rd_seq),
        .result      (match)
    );

    // A hit is only meaningful when a read landed in the previous cycle.
    assign hit_now  = rd_pend_reg && match.hit;
    // All entries issued; the last one (if any) is being compared this same cycle.
    assign scan_end = (scan_cnt_reg == count_reg);
    // Keep issuing reads until every entry is out or a hit stops the walk.
    assign rd_en    = (state_reg == ST_SCAN) && !scan_end && !hit_now;

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        blk_next         = blk_reg;
        seq_next         = seq_reg;
        count_next       = count_reg;
        scan_cnt_next    = scan_cnt_reg;
        rd_pend_next     = 1'b0;
        rd_idx_next      = rd_idx_reg;
        revoked_next     = revoked_reg;
        full_next        = full_reg;
        out_revoked_next = out_revoked_reg;
        out_full_next    = out_full_reg;
        out_used_next    = out_used_reg;
        wr_en            = 1'b0;
        wr_addr          = rd_idx_reg;

        // Drop the result once the downstream side takes it.
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // Capture the request and pick the path by function.
                    op_next       = jrt_pkg::func_t'(s_func);
                    blk_next      = s_block_number;
                    seq_next      = s_sequence_req;
                    revoked_next  = 1'b0;
                    full_next     = 1'b0;
                    scan_cnt_next = '0;
                    case (jrt_pkg::func_t'(s_func))
                        jrt_pkg::FUNC_CLEAR: begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        jrt_pkg::FUNC_REMEMBER,
                        jrt_pkg::FUNC_QUERY: begin
                            state_next = ST_SCAN;
                        end
                        default: begin
                            // Unused code: leave the table alone.
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Advance the read pointer; track which entry is in flight.
                rd_pend_next = rd_en;
                rd_idx_next  = scan_cnt_reg[AW-1:0];
                if (rd_en) begin
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end

                if (hit_now) begin
                    state_next = ST_DONE;
                    if (op_reg == jrt_pkg::FUNC_QUERY) begin
                        revoked_next = match.seq_ge;
                    end else if (!match.seq_ge) begin
                        // Raise the stored sequence to the newer one.
                        wr_en   = 1'b1;
                        wr_addr = rd_idx_reg;
                    end
                end else if (scan_end) begin
                    state_next = ST_DONE;
                    if (op_reg == jrt_pkg::FUNC_REMEMBER) begin
                        if (count_reg == CW'(TABLE_DEPTH)) begin
                            full_next = 1'b1;
                        end else begin
                            // Append the new block at the end of the table.
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end

            ST_DONE: begin
                // Hold the result until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    out_revoked_next = revoked_reg;
                    out_full_next    = full_reg;
                    out_used_next    = jrt_pkg::USED_W'(count_reg);
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        blk_reg         <= blk_next;
        seq_reg         <= seq_next;
        rd_idx_reg      <= rd_idx_next;
        revoked_reg     <= revoked_next;
        full_reg        <= full_next;
        out_revoked_reg <= out_revoked_next;
        out_full_reg    <= out_full_next;
        out_used_reg    <= out_used_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

// ===== design/jrt_checker.sv =====
// ----------------------------------------------------------------------------
// jrt_checker: port-level checks for the journal revoke table
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module jrt_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_is_revoked,
    input logic                         m_table_full_error,
    input logic [jrt_pkg::USED_W-1:0]   m_entries_used
);

    // No result may be shown in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_revoked) &&
            $stable(m_table_full_error) && $stable(m_entries_used))
        else $error("stalled result changed");

    // One request at a time: the block goes busy after every accept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // A full-table error comes only from remember, never with a query hit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_table_full_error && m_is_revoked))
        else $error("full error and revoked both set");

endmodule

bind journal_revoke_table_core jrt_checker u_jrt_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_is_revoked       (m_is_revoked),
    .m_table_full_error (m_table_full_error),
    .m_entries_used     (m_entries_used)
);
